// ===== sv/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// shared codes and constants for the box versus frustum plane test
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int IDX_W     = 3;
	localparam int FRAC_BITS = 16;
	localparam int NUM_VALS  = 6;
	localparam int CMP_W     = 5;

	// item codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TEST  = 1'b1;

	// value slots of a queue entry
	localparam int SLOT_NX    = 0;
	localparam int SLOT_NY    = 1;
	localparam int SLOT_NZ    = 2;
	localparam int SLOT_D     = 3;
	localparam int SLOT_MIN_X = 0;
	localparam int SLOT_MIN_Y = 1;
	localparam int SLOT_MIN_Z = 2;
	localparam int SLOT_MAX_X = 3;
	localparam int SLOT_MAX_Y = 4;
	localparam int SLOT_MAX_Z = 5;

endpackage

// ===== sv/afc_front.sv =====
// ----------------------------------------------------------------------------
// afc_front
// takes items, packs plane writes and box tests into a two-entry queue
// ----------------------------------------------------------------------------
module afc_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [afc_pkg::IDX_W-1:0]     plane_index,
	input  logic signed [VALUE_WIDTH-1:0] normal_x,
	input  logic signed [VALUE_WIDTH-1:0] normal_y,
	input  logic signed [VALUE_WIDTH-1:0] normal_z,
	input  logic signed [VALUE_WIDTH-1:0] offset_d,
	input  logic signed [VALUE_WIDTH-1:0] min_x,
	input  logic signed [VALUE_WIDTH-1:0] min_y,
	input  logic signed [VALUE_WIDTH-1:0] min_z,
	input  logic signed [VALUE_WIDTH-1:0] max_x,
	input  logic signed [VALUE_WIDTH-1:0] max_y,
	input  logic signed [VALUE_WIDTH-1:0] max_z,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic                          q_func,
	output logic [afc_pkg::IDX_W-1:0]     q_index,
	output logic [VALUE_WIDTH-1:0]        q_val [afc_pkg::NUM_VALS]
);
	import afc_pkg::*;

	logic                   func_q  [2];
	logic [IDX_W-1:0]       idx_q   [2];
	logic [VALUE_WIDTH-1:0] val_q   [2][NUM_VALS];
	logic [VALUE_WIDTH-1:0] pack    [NUM_VALS];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   push;

	assign busy    = (count_q == 2'd2);
	assign push    = start & ~busy;
	assign q_valid = (count_q != 2'd0);
	assign q_func  = func_q[rd_ptr_q];
	assign q_index = idx_q[rd_ptr_q];
	assign q_val   = val_q[rd_ptr_q];

	// classify: a box test carries its corners, a write its plane
	always_comb begin
		if (func == FUNC_TEST) begin
			pack[SLOT_MIN_X] = min_x;
			pack[SLOT_MIN_Y] = min_y;
			pack[SLOT_MIN_Z] = min_z;
			pack[SLOT_MAX_X] = max_x;
			pack[SLOT_MAX_Y] = max_y;
			pack[SLOT_MAX_Z] = max_z;
		end else begin
			pack[SLOT_NX] = normal_x;
			pack[SLOT_NY] = normal_y;
			pack[SLOT_NZ] = normal_z;
			pack[SLOT_D]  = offset_d;
			pack[4]       = '0;
			pack[5]       = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			func_q[wr_ptr_q] <= func;
			idx_q[wr_ptr_q]  <= plane_index;
			val_q[wr_ptr_q]  <= pack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== sv/afc_back.sv =====
// ----------------------------------------------------------------------------
// afc_back
// plane store and shared dot unit, one plane per cycle, result strobe
// ----------------------------------------------------------------------------
module afc_back #(
	parameter int NUM_PLANES  = 6,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  logic                      q_func,
	input  logic [afc_pkg::IDX_W-1:0] q_index,
	input  logic [VALUE_WIDTH-1:0]    q_val [afc_pkg::NUM_VALS],
	output logic                      done,
	output logic                      visible
);
	import afc_pkg::*;

	localparam int PL_W   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int PROD_W = 2 * VALUE_WIDTH;
	localparam int OFF_W  = VALUE_WIDTH + FRAC_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic [PL_W-1:0] LAST = PL_W'(NUM_PLANES - 1);

	typedef enum logic {IDLE, TEST} state_t;

	state_t                        state_q;
	logic [PL_W-1:0]               plane_q;
	logic signed [VALUE_WIDTH-1:0] box_min_q [3];
	logic signed [VALUE_WIDTH-1:0] box_max_q [3];
	logic signed [VALUE_WIDTH-1:0] nx_q [NUM_PLANES];
	logic signed [VALUE_WIDTH-1:0] ny_q [NUM_PLANES];
	logic signed [VALUE_WIDTH-1:0] nz_q [NUM_PLANES];
	logic signed [VALUE_WIDTH-1:0] d_q  [NUM_PLANES];

	logic                          issue;
	logic                          at_last;
	logic signed [VALUE_WIDTH-1:0] n_sel [3];
	logic signed [VALUE_WIDTH-1:0] c_sel [3];

	logic signed [PROD_W-1:0]      p0_s1, p1_s1, p2_s1;
	logic signed [OFF_W-1:0]       off_s1;
	logic                          valid_s1, first_s1, last_s1;

	logic signed [SUM_W-1:0]       sum;
	logic                          neg;
	logic                          vis_next;
	logic                          vis_q;

	assign issue   = (state_q == TEST);
	assign at_last = (plane_q == LAST);
	assign q_pop   = q_valid & ((state_q == IDLE) | at_last);

	// p-vertex: max corner where the normal component is not negative
	always_comb begin
		n_sel[0] = nx_q[plane_q];
		n_sel[1] = ny_q[plane_q];
		n_sel[2] = nz_q[plane_q];
		for (int a = 0; a < 3; a++)
			c_sel[a] = n_sel[a][VALUE_WIDTH-1] ? box_min_q[a] : box_max_q[a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				nx_q[i] <= '0;
				ny_q[i] <= '0;
				nz_q[i] <= '0;
				d_q[i]  <= '0;
			end
		end else if (q_pop && q_func == FUNC_WRITE) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (CMP_W'(q_index) == CMP_W'(i)) begin
					nx_q[i] <= q_val[SLOT_NX];
					ny_q[i] <= q_val[SLOT_NY];
					nz_q[i] <= q_val[SLOT_NZ];
					d_q[i]  <= q_val[SLOT_D];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_func == FUNC_TEST) begin
			box_min_q[0] <= q_val[SLOT_MIN_X];
			box_min_q[1] <= q_val[SLOT_MIN_Y];
			box_min_q[2] <= q_val[SLOT_MIN_Z];
			box_max_q[0] <= q_val[SLOT_MAX_X];
			box_max_q[1] <= q_val[SLOT_MAX_Y];
			box_max_q[2] <= q_val[SLOT_MAX_Z];
		end
		p0_s1  <= n_sel[0] * c_sel[0];
		p1_s1  <= n_sel[1] * c_sel[1];
		p2_s1  <= n_sel[2] * c_sel[2];
		off_s1 <= {d_q[plane_q], {FRAC_BITS{1'b0}}};
	end

	// sequencer: walks the planes of one box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			plane_q  <= '0;
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			first_s1 <= issue & (plane_q == '0);
			last_s1  <= issue & at_last;
			case (state_q)
				IDLE: begin
					if (q_pop && q_func == FUNC_TEST) begin
						state_q <= TEST;
						plane_q <= '0;
					end
				end
				TEST: begin
					if (at_last) begin
						plane_q <= '0;
						if (!(q_pop && q_func == FUNC_TEST))
							state_q <= IDLE;
					end else begin
						plane_q <= plane_q + PL_W'(1);
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign sum = SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1) + SUM_W'(off_s1);
	assign neg = sum[SUM_W-1];
	assign vis_next = (first_s1 ? 1'b1 : vis_q) & ~neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q   <= 1'b1;
			done    <= 1'b0;
			visible <= 1'b0;
		end else begin
			done <= valid_s1 & last_s1;
			if (valid_s1) begin
				vis_q   <= vis_next;
				visible <= vis_next;
			end
		end
	end

endmodule

// ===== sv/aabb_frustum_cull_test_top.sv =====
// a box test strobes done after the queue, the plane walk, the product registers and
// the done register; the shared three-multiplier dot unit takes one plane per cycle
// and the back end takes the next box on the last plane of the current one
// a two-entry queue decouples intake from the dot unit; busy is high while it is full
// reset clears the queue, the sequencer and all planes to zero; results cannot stall
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_top
// axis-aligned box versus NUM_PLANES (six by default) inward-facing frustum planes, p-vertex test
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_top #(
	parameter int NUM_PLANES  = 6,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [afc_pkg::IDX_W-1:0]     plane_index,
	input  logic signed [VALUE_WIDTH-1:0] normal_x,
	input  logic signed [VALUE_WIDTH-1:0] normal_y,
	input  logic signed [VALUE_WIDTH-1:0] normal_z,
	input  logic signed [VALUE_WIDTH-1:0] offset_d,
	input  logic signed [VALUE_WIDTH-1:0] min_x,
	input  logic signed [VALUE_WIDTH-1:0] min_y,
	input  logic signed [VALUE_WIDTH-1:0] min_z,
	input  logic signed [VALUE_WIDTH-1:0] max_x,
	input  logic signed [VALUE_WIDTH-1:0] max_y,
	input  logic signed [VALUE_WIDTH-1:0] max_z,
	output logic                          done,
	output logic                          visible
);
	import afc_pkg::*;

	logic                   q_valid;
	logic                   q_pop;
	logic                   q_func;
	logic [IDX_W-1:0]       q_index;
	logic [VALUE_WIDTH-1:0] q_val [NUM_VALS];

	afc_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.plane_index (plane_index),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.offset_d    (offset_d),
		.min_x       (min_x),
		.min_y       (min_y),
		.min_z       (min_z),
		.max_x       (max_x),
		.max_y       (max_y),
		.max_z       (max_z),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_func      (q_func),
		.q_index     (q_index),
		.q_val       (q_val)
	);

	afc_back #(
		.NUM_PLANES  (NUM_PLANES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_func  (q_func),
		.q_index (q_index),
		.q_val   (q_val),
		.done    (done),
		.visible (visible)
	);

endmodule
